// ----- hdl/hbrl_pkg.sv -----
// ----------------------------------------------------------------------------
// hbrl_pkg
// Shared widths, defaults and codes of the per-host backoff rate limiter.
// ----------------------------------------------------------------------------
package hbrl_pkg;

	localparam int HOST_SLOTS_DEF = 64;
	localparam int TIME_BITS_DEF  = 48;

	localparam int OP_W       = 2;
	localparam int SLOT_W     = 6;
	localparam int HINT_W     = 32;
	localparam int STATUS_W   = 2;
	localparam int WAIT_W     = 25;
	localparam int PEN_W      = 20;
	localparam int BASE_W     = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [BASE_W-1:0] BASE_DELAY_RST  = BASE_W'(1000);
	localparam logic [PEN_W-1:0]  MIN_BACKOFF_RST = PEN_W'(10000);
	localparam logic [PEN_W-1:0]  MAX_BACKOFF_RST = PEN_W'(300000);
	localparam logic [WAIT_W-1:0] WAIT_MAX        = '1;

	typedef enum logic [OP_W-1:0] {
		OP_REQUEST  = 2'd0,
		OP_SUCCESS  = 2'd1,
		OP_THROTTLE = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED = 2'd0,
		ST_WAIT    = 2'd1,
		ST_IGNORED = 2'd2,
		ST_PENALTY = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_DELAY  = 2'd0,
		CFG_MIN_BACKOFF = 2'd1,
		CFG_MAX_BACKOFF = 2'd2
	} cfg_idx_t;

endpackage

// ----- hdl/hbrl_if.sv -----
// ----------------------------------------------------------------------------
// hbrl_if
// Handshake channels of the rate limiter: request, result and register write.
// ----------------------------------------------------------------------------
interface hbrl_in_if #(
	parameter int TIME_BITS = hbrl_pkg::TIME_BITS_DEF
);
	import hbrl_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic                 host_valid;
	logic [SLOT_W-1:0]    host_slot;
	logic [TIME_BITS-1:0] now_ms;
	logic [HINT_W-1:0]    retry_hint;
	modport source (output valid, op, host_valid, host_slot, now_ms, retry_hint, input ready);
	modport sink (input valid, op, host_valid, host_slot, now_ms, retry_hint, output ready);
endinterface

interface hbrl_out_if;
	import hbrl_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [WAIT_W-1:0]   wait_ms;
	logic [PEN_W-1:0]    penalty_now;
	modport source (output valid, status, wait_ms, penalty_now, input ready);
	modport sink (input valid, status, wait_ms, penalty_now, output ready);
endinterface

interface hbrl_cfg_if;
	import hbrl_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/host_backoff_rate_limiter_unit.sv -----
// ----------------------------------------------------------------------------
// host_backoff_rate_limiter_unit
// Per-host rate limiter with exponential backoff over a table of host slots.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one word per event: op (request turn, mark success, mark
//   throttled), host_valid, host_slot, now_ms and retry_hint. rsp returns one
//   word per request word: status, wait_ms and penalty_now.
//   cfg writes base_delay (index 0), min_backoff (1) and max_backoff (2); it
//   is always ready and should be used only while the block is idle.
//   Each word reads its host entry from the table memory, then updates it
//   and writes it back. The table has a single read port; a new word is not
//   taken until the last one has left the update step and its result has
//   been loaded into the output register.
//   After reset the table is swept to zero, one entry per cycle, through all
//   HOST_SLOTS entries; req is not ready during the sweep.
//   When rsp stalls, one result is held in the output register and the next
//   word is still taken and read; it then waits in the update step until
//   the output register frees.
// ----------------------------------------------------------------------------
module host_backoff_rate_limiter_unit #(
	parameter int HOST_SLOTS = hbrl_pkg::HOST_SLOTS_DEF,
	parameter int TIME_BITS  = hbrl_pkg::TIME_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	hbrl_cfg_if.sink   cfg,
	hbrl_in_if.sink    req,
	hbrl_out_if.source rsp
);
	import hbrl_pkg::*;

	localparam int AW = (HOST_SLOTS > 1) ? $clog2(HOST_SLOTS) : 1;

	typedef struct packed {
		logic [PEN_W-1:0]     pen;
		logic [TIME_BITS-1:0] nxt;
	} entry_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         clr_q;
	logic [BASE_W-1:0]     base_q;
	logic [PEN_W-1:0]      min_q;
	logic [PEN_W-1:0]      max_q;

	logic [OP_W-1:0]       op_q;
	logic                  act_q;
	logic [AW-1:0]         idx_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [HINT_W-1:0]     hint_q;

	logic                  rsp_vld_q;
	logic [STATUS_W-1:0]   rsp_status_q;
	logic [WAIT_W-1:0]     rsp_wait_q;
	logic [PEN_W-1:0]      rsp_pen_q;

	entry_t                mem [HOST_SLOTS];
	entry_t                rd_s1;

	logic [SLOT_W+AW-1:0]  slot_ext;
	logic [AW-1:0]         req_idx;
	logic [AW-1:0]         rd_idx;
	logic                  req_act;
	logic                  accept;
	logic                  out_free;
	logic                  fire_ex;
	logic                  clearing;

	logic                  late;
	logic [TIME_BITS-1:0]  diff;
	logic [WAIT_W-1:0]     wait_v;
	logic [WAIT_W-1:0]     eff;
	logic [PEN_W:0]        nb_soft;
	logic [HINT_W-1:0]     nb;
	logic [PEN_W-1:0]      pen_thr;
	logic [WAIT_W-1:0]     addend;
	logic [TIME_BITS:0]    sum;
	logic [TIME_BITS-1:0]  nxt_new;

	logic                  we_ex;
	entry_t                wdata_ex;
	logic [STATUS_W-1:0]   res_status;
	logic [WAIT_W-1:0]     res_wait;
	logic [PEN_W-1:0]      res_pen;

	logic                  mem_we;
	logic [AW-1:0]         wr_idx;
	entry_t                wr_data;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_vld_q || rsp.ready;
	assign fire_ex   = (state_q == S_EXEC) && out_free;
	assign clearing  = (state_q == S_CLEAR);

	assign slot_ext = (SLOT_W + AW)'(req.host_slot);
	assign req_idx  = slot_ext[AW-1:0];
	assign req_act  = req.host_valid && (32'(req.host_slot) < 32'(HOST_SLOTS))
		&& (req.op == OP_REQUEST || req.op == OP_SUCCESS || req.op == OP_THROTTLE);
	assign rd_idx   = (state_q == S_IDLE) ? req_idx : idx_q;

	// table memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx] <= wr_data;
		end
		rd_s1 <= mem[rd_idx];
	end

	// entry update
	always_comb begin
		late    = (now_q >= rd_s1.nxt);
		diff    = rd_s1.nxt - now_q;
		wait_v  = (|diff[TIME_BITS-1:WAIT_W]) ? WAIT_MAX : diff[WAIT_W-1:0];
		eff     = WAIT_W'(base_q) + WAIT_W'(rd_s1.pen);
		nb_soft = (rd_s1.pen == '0) ? (PEN_W + 1)'(min_q) : {rd_s1.pen, 1'b0};
		nb      = (hint_q != '0) ? hint_q : HINT_W'(nb_soft);
		pen_thr = (nb > HINT_W'(max_q)) ? max_q : nb[PEN_W-1:0];
		addend  = (op_q == OP_REQUEST) ? eff : WAIT_W'(pen_thr);
		sum     = (TIME_BITS + 1)'(now_q) + (TIME_BITS + 1)'(addend);
		nxt_new = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

		we_ex      = 1'b0;
		wdata_ex   = rd_s1;
		res_status = ST_IGNORED;
		res_wait   = '0;
		res_pen    = '0;
		if (act_q) begin
			unique case (op_q)
				OP_REQUEST: begin
					res_pen = rd_s1.pen;
					if (late) begin
						res_status   = ST_GRANTED;
						we_ex        = 1'b1;
						wdata_ex.nxt = nxt_new;
					end else begin
						res_status = ST_WAIT;
						res_wait   = wait_v;
					end
				end
				OP_SUCCESS: begin
					res_status   = ST_PENALTY;
					we_ex        = 1'b1;
					wdata_ex.pen = rd_s1.pen >> 1;
					res_pen      = rd_s1.pen >> 1;
				end
				OP_THROTTLE: begin
					res_status   = ST_PENALTY;
					we_ex        = 1'b1;
					wdata_ex.pen = pen_thr;
					wdata_ex.nxt = nxt_new;
					res_pen      = pen_thr;
				end
				default: begin
					res_status = ST_IGNORED;
				end
			endcase
		end
	end

	assign mem_we  = clearing || (fire_ex && we_ex);
	assign wr_idx  = clearing ? clr_q : idx_q;
	assign wr_data = clearing ? '0 : wdata_ex;

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_DELAY_RST;
			min_q  <= MIN_BACKOFF_RST;
			max_q  <= MAX_BACKOFF_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_BASE_DELAY:  base_q <= cfg.data[BASE_W-1:0];
				CFG_MIN_BACKOFF: min_q  <= cfg.data[PEN_W-1:0];
				CFG_MAX_BACKOFF: max_q  <= cfg.data[PEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			op_q         <= '0;
			act_q        <= 1'b0;
			idx_q        <= '0;
			now_q        <= '0;
			hint_q       <= '0;
			rsp_vld_q    <= 1'b0;
			rsp_status_q <= '0;
			rsp_wait_q   <= '0;
			rsp_pen_q    <= '0;
		end else begin
			if (rsp_vld_q && rsp.ready && !fire_ex) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(HOST_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q    <= req.op;
						act_q   <= req_act;
						idx_q   <= req_idx;
						now_q   <= req.now_ms;
						hint_q  <= req.retry_hint;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						rsp_vld_q    <= 1'b1;
						rsp_status_q <= res_status;
						rsp_wait_q   <= res_wait;
						rsp_pen_q    <= res_pen;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.wait_ms     = rsp_wait_q;
	assign rsp.penalty_now = rsp_pen_q;

`ifndef NO_ASSERTIONS
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !req.ready)
		else $error("word taken during table sweep");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("taken word did not enter update step");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (clearing || state_q == S_EXEC))
		else $error("table written outside sweep or update");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_vld_q && !rsp.ready) |=> (rsp_vld_q && $stable(rsp_status_q)
			&& $stable(rsp_wait_q) && $stable(rsp_pen_q)))
		else $error("held result overwritten");
`endif

endmodule

// ----- tb/tb_host_backoff_rate_limiter_unit.sv -----
// ----------------------------------------------------------------------------
// tb_host_backoff_rate_limiter_unit
// Self-checking bench for the per-host backoff rate limiter. Request words are
// driven through the req channel with random gaps. A local model of the host
// table (penalty, next-allowed time) and registers predicts each result.
// Results on rsp are checked field by field against the oldest prediction,
// with random stalls and one long hold-off on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_host_backoff_rate_limiter_unit;

	import hbrl_pkg::*;

	localparam int TW          = TIME_BITS_DEF;
	localparam int SLOTS       = HOST_SLOTS_DEF;
	localparam int HOLD_CYCLES = 80;
	localparam logic [TW-1:0]   TIME_MAX     = '1;
	localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic              host_valid;
		logic [SLOT_W-1:0] slot;
		logic [TW-1:0]     now;
		logic [HINT_W-1:0] hint;
	} rq_word_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [WAIT_W-1:0]   wait_ms;
		logic [PEN_W-1:0]    penalty;
	} verdict_t;

	logic clk;
	logic arst_n;

	hbrl_in_if #(.TIME_BITS(TW)) req_if ();
	hbrl_out_if rsp_if ();
	hbrl_cfg_if cfg_if ();

	host_backoff_rate_limiter_unit #(
		.HOST_SLOTS(SLOTS),
		.TIME_BITS (TW)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_if),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	// host table and registers as the block should hold them
	logic [PEN_W-1:0]  host_pen  [SLOTS];
	logic [TW-1:0]     host_next [SLOTS];
	logic [BASE_W-1:0] cfg_base;
	logic [PEN_W-1:0]  cfg_min;
	logic [PEN_W-1:0]  cfg_max;

	verdict_t      verdict_q[$];
	verdict_t      want;
	int            fail_cnt;
	int            snd_idle_pct;
	int            rcv_idle_pct;
	bit            hold_off_req;
	logic [TW-1:0] wall_ms;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("host_backoff_rate_limiter_unit test failed");
		$finish;
	end

	function automatic logic [TW-1:0] sat_after(input logic [TW-1:0] t, input logic [63:0] d);
		logic [63:0] s;
		s = 64'(t) + d;
		return (s > 64'(TIME_MAX)) ? TIME_MAX : s[TW-1:0];
	endfunction

	function automatic verdict_t limiter_verdict(input rq_word_t w);
		verdict_t         v;
		logic [PEN_W-1:0] pen;
		logic [TW-1:0]    gap;
		logic [63:0]      nb;
		v.status  = ST_IGNORED;
		v.wait_ms = '0;
		v.penalty = '0;
		if (!w.host_valid || int'(w.slot) >= SLOTS)
			return v;
		pen = host_pen[w.slot];
		case (w.op)
			OP_REQUEST: begin
				if (w.now >= host_next[w.slot]) begin
					host_next[w.slot] = sat_after(w.now, 64'(cfg_base) + 64'(pen));
					v.status = ST_GRANTED;
				end else begin
					gap = host_next[w.slot] - w.now;
					v.wait_ms = (gap > TW'(WAIT_MAX)) ? WAIT_MAX : gap[WAIT_W-1:0];
					v.status = ST_WAIT;
				end
			end
			OP_SUCCESS: begin
				pen = pen >> 1;
				host_pen[w.slot] = pen;
				v.status = ST_PENALTY;
			end
			OP_THROTTLE: begin
				if (w.hint != '0)
					nb = 64'(w.hint);
				else if (pen == '0)
					nb = 64'(cfg_min);
				else
					nb = 64'(pen) << 1;
				if (nb > 64'(cfg_max))
					nb = 64'(cfg_max);
				pen = nb[PEN_W-1:0];
				host_pen[w.slot] = pen;
				host_next[w.slot] = sat_after(w.now, 64'(pen));
				v.status = ST_PENALTY;
			end
			default: begin
				return v;
			end
		endcase
		v.penalty = pen;
		return v;
	endfunction

	function automatic rq_word_t mk_word(input logic [OP_W-1:0] op, input logic hv,
		input logic [SLOT_W-1:0] slot, input logic [TW-1:0] now, input logic [HINT_W-1:0] hint);
		rq_word_t w;
		w.op         = op;
		w.host_valid = hv;
		w.slot       = slot;
		w.now        = now;
		w.hint       = hint;
		return w;
	endfunction

	// mostly well-formed traffic on a few hot hosts with a slowly advancing clock
	function automatic rq_word_t next_traffic_word();
		rq_word_t w;
		int       pick;
		int       span;
		int       r;
		pick = $urandom_range(0, 99);
		span = int'(cfg_base >> 1) + int'(cfg_max >> 2) + 2000;
		w.host_valid = 1'b1;
		w.slot = ($urandom_range(0, 3) == 0) ? SLOT_W'($urandom_range(0, SLOTS - 1))
			: SLOT_W'($urandom_range(0, 5));
		w.hint = '0;
		if (pick < 55)
			w.op = OP_REQUEST;
		else if (pick < 72)
			w.op = OP_SUCCESS;
		else if (pick < 92)
			w.op = OP_THROTTLE;
		else if (pick < 96) begin
			w.op = OP_W'($urandom_range(0, 3));
			w.host_valid = 1'b0;
		end else
			w.op = OP_UNDEFINED;
		if (w.op == OP_THROTTLE) begin
			case ($urandom_range(0, 3))
				2: w.hint = HINT_W'($urandom_range(1, 2 * int'(cfg_max) + 2));
				3: w.hint = HINT_W'($urandom());
				default: w.hint = '0;
			endcase
		end else if ($urandom_range(0, 4) == 0)
			w.hint = HINT_W'($urandom());
		r = $urandom_range(0, 199);
		if (r == 0)
			wall_ms = TW'({$urandom(), $urandom()});
		else if (r == 1)
			wall_ms = TIME_MAX - TW'($urandom_range(0, 3000));
		else
			wall_ms = wall_ms + TW'($urandom_range(0, span));
		w.now = ($urandom_range(0, 32) == 0) ? TW'({$urandom(), $urandom()}) : wall_ms;
		return w;
	endfunction

	task automatic send_word(input rq_word_t w);
		int gap;
		if (snd_idle_pct > 0 && $urandom_range(0, 99) < snd_idle_pct) begin
			gap = $urandom_range(1, 11);
			@(negedge clk);
			req_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_if.valid      <= 1'b1;
		req_if.op         <= w.op;
		req_if.host_valid <= w.host_valid;
		req_if.host_slot  <= w.slot;
		req_if.now_ms     <= w.now;
		req_if.retry_hint <= w.hint;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		verdict_q.push_back(limiter_verdict(w));
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		case (idx)
			CFG_BASE_DELAY:  cfg_base = val[BASE_W-1:0];
			CFG_MIN_BACKOFF: cfg_min  = val[PEN_W-1:0];
			CFG_MAX_BACKOFF: cfg_max  = val[PEN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic run_traffic(input int n);
		repeat (n) send_word(next_traffic_word());
	endtask

	task automatic test_reset_defaults();
		snd_idle_pct = 20;
		rcv_idle_pct = 20;
		send_word(mk_word(OP_REQUEST, 1'b1, 6'd0, 48'd0, '0));
		send_word(mk_word(OP_REQUEST, 1'b1, 6'd0, 48'd999, '0));
		send_word(mk_word(OP_REQUEST, 1'b1, 6'd0, 48'd1000, '1));
		send_word(mk_word(OP_SUCCESS, 1'b1, 6'd0, 48'd1500, '0));
		send_word(mk_word(OP_THROTTLE, 1'b1, 6'd0, 48'd2000, '0));
		send_word(mk_word(OP_THROTTLE, 1'b1, 6'd0, 48'd2000, '0));
		send_word(mk_word(OP_REQUEST, 1'b1, 6'd0, 48'd2001, '0));
		send_word(mk_word(OP_THROTTLE, 1'b1, 6'd0, 48'd2100, 32'd1));
		send_word(mk_word(OP_THROTTLE, 1'b1, 6'd0, 48'd2200, '1));
		send_word(mk_word(OP_SUCCESS, 1'b1, 6'd0, 48'd2300, '1));
		send_word(mk_word(OP_THROTTLE, 1'b1, 6'd0, 48'd2400, '0));
		send_word(mk_word(OP_REQUEST, 1'b0, 6'd0, TIME_MAX, '1));
		send_word(mk_word(OP_SUCCESS, 1'b0, 6'd0, 48'd0, '1));
		send_word(mk_word(OP_THROTTLE, 1'b0, 6'd0, 48'd0, '1));
		send_word(mk_word(OP_UNDEFINED, 1'b1, 6'd0, 48'd0, '1));
		// next-allowed saturates at the top of the time range
		send_word(mk_word(OP_REQUEST, 1'b1, 6'd63, TIME_MAX, '0));
		send_word(mk_word(OP_REQUEST, 1'b1, 6'd63, TIME_MAX, '0));
		// far-off next-allowed: wait saturates
		send_word(mk_word(OP_REQUEST, 1'b1, 6'd63, 48'd0, '0));
		send_word(mk_word(OP_THROTTLE, 1'b1, 6'd62, TIME_MAX - 48'd5, '0));
		send_word(mk_word(OP_SUCCESS, 1'b1, 6'd62, 48'd7, '0));
		send_word(mk_word(OP_REQUEST, 1'b1, 6'd62, 48'd7, '0));
		drain_results();
	endtask

	task automatic test_register_settings();
		logic [CFG_DATA_W-1:0] base_set [5];
		logic [CFG_DATA_W-1:0] min_set  [5];
		logic [CFG_DATA_W-1:0] max_set  [5];
		base_set = '{24'd0, 24'hFFFFFF, 24'd1, 24'd0, 24'($urandom_range(0, 5000))};
		min_set  = '{24'd0, 24'hFFFFF, 24'hFFFFF, 24'd1, 24'($urandom_range(0, 40000))};
		max_set  = '{24'd0, 24'hFFFFF, 24'd5, 24'hFFFFF, 24'($urandom_range(0, 1048575))};
		for (int k = 0; k < 5; k++) begin
			drain_results();
			write_reg(CFG_BASE_DELAY, base_set[k]);
			write_reg(CFG_MIN_BACKOFF, min_set[k]);
			write_reg(CFG_MAX_BACKOFF, max_set[k]);
			snd_idle_pct = 10 * k;
			rcv_idle_pct = 40 - 10 * k;
			run_traffic(150);
		end
		drain_results();
		write_reg(CFG_BASE_DELAY, 24'(BASE_DELAY_RST));
		write_reg(CFG_MIN_BACKOFF, 24'(MIN_BACKOFF_RST));
		write_reg(CFG_MAX_BACKOFF, 24'(MAX_BACKOFF_RST));
	endtask

	task automatic test_output_hold_off();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_off_req = 1'b1;
		run_traffic(24);
		wait (!hold_off_req);
		drain_results();
	endtask

	task automatic test_mixed_traffic();
		int pct [4];
		pct = '{0, 8, 25, 50};
		for (int k = 0; k < 8; k++) begin
			snd_idle_pct = pct[$urandom_range(0, 3)];
			rcv_idle_pct = pct[$urandom_range(0, 3)];
			run_traffic(100);
		end
		drain_results();
	endtask

	task automatic test_steady_stream();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		run_traffic(160);
	endtask

	task automatic finish_run();
		int n;
		@(negedge clk);
		req_if.valid <= 1'b0;
		for (n = 0; n < 4000 && verdict_q.size() != 0; n++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (verdict_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, verdict_q.size());
			fail_cnt++;
		end
		if (fail_cnt == 0)
			$display("host_backoff_rate_limiter_unit test passed");
		else
			$display("host_backoff_rate_limiter_unit test failed");
		$finish;
	endtask

	// result side pacing: random stalls, or one long hold-off on request
	initial begin : rsp_pacer
		int n;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				rsp_if.ready <= 1'b0;
				n = 1;
				while (n < HOLD_CYCLES) begin
					@(negedge clk);
					n++;
				end
				hold_off_req = 1'b0;
			end else if (rcv_idle_pct > 0 && $urandom_range(0, 99) < rcv_idle_pct) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(0, 10)) @(negedge clk);
			end else
				rsp_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (verdict_q.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 50)
					$display("%0t: unexpected result: status %0d wait_ms %0d penalty_now %0d",
						$time, rsp_if.status, rsp_if.wait_ms, rsp_if.penalty_now);
			end else begin
				want = verdict_q.pop_front();
				if (rsp_if.status !== want.status || rsp_if.wait_ms !== want.wait_ms ||
					rsp_if.penalty_now !== want.penalty) begin
					fail_cnt++;
					if (fail_cnt <= 50)
						$display("%0t: expected status %0d wait_ms %0d penalty_now %0d, %s %0d %0d %0d",
							$time, want.status, want.wait_ms, want.penalty, "actual",
							rsp_if.status, rsp_if.wait_ms, rsp_if.penalty_now);
				end
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		req_if.valid      = 1'b0;
		req_if.op         = OP_REQUEST;
		req_if.host_valid = 1'b0;
		req_if.host_slot  = '0;
		req_if.now_ms     = '0;
		req_if.retry_hint = '0;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = CFG_BASE_DELAY;
		cfg_if.data       = '0;
		fail_cnt          = 0;
		hold_off_req      = 1'b0;
		snd_idle_pct      = 0;
		rcv_idle_pct      = 0;
		wall_ms           = '0;
		cfg_base          = BASE_DELAY_RST;
		cfg_min           = MIN_BACKOFF_RST;
		cfg_max           = MAX_BACKOFF_RST;
		for (int i = 0; i < SLOTS; i++) begin
			host_pen[i]  = '0;
			host_next[i] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_register_settings();
		test_output_hold_off();
		test_mixed_traffic();
		test_steady_stream();
		finish_run();
	end

endmodule

// ----- host_backoff_rate_limiter_unit.f -----
hdl/hbrl_pkg.sv
hdl/hbrl_if.sv
hdl/host_backoff_rate_limiter_unit.sv
tb/tb_host_backoff_rate_limiter_unit.sv
